// ===== rtl/crsfr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crsfr_pkg
// Shared types, constants and helper functions of the rc frame receiver.
// ----------------------------------------------------------------------------
package crsfr_pkg;

   localparam int NUM_CHANNELS    = 16;
   localparam int MAX_FRAME_BYTES = 64;
   localparam int PAYLOAD_BYTES   = 22;
   localparam int PAYLOAD_BITS    = PAYLOAD_BYTES * 8;
   localparam int PAYLOAD_IDX_W   = $clog2(PAYLOAD_BYTES);
   localparam int CH_BITS         = 11;
   localparam int JOB_QUEUE_DEPTH = 2;
   localparam int JQ_PTR_W        = (JOB_QUEUE_DEPTH > 1) ? $clog2(JOB_QUEUE_DEPTH) : 1;
   localparam int JQ_CNT_W        = $clog2(JOB_QUEUE_DEPTH + 1);

   localparam logic [7:0]  RC_TYPE       = 8'h16;
   localparam logic [5:0]  RC_LENGTH     = 6'd24;
   localparam logic [7:0]  CRC_POLY      = 8'hD5;
   localparam logic [15:0] TIMEOUT_RESET = 16'd500;
   localparam logic [7:0]  MIN_LENGTH    = 8'd2;
   localparam logic [7:0]  MAX_LENGTH    = 8'(MAX_FRAME_BYTES - 2);

   localparam logic [7:0] ADDR_FC        = 8'hC8;
   localparam logic [7:0] ADDR_RADIO     = 8'hEA;
   localparam logic [7:0] ADDR_RECEIVER  = 8'hEC;
   localparam logic [7:0] ADDR_TX        = 8'hEE;
   localparam logic [7:0] ADDR_BROADCAST = 8'h00;

   typedef enum logic {
      FUNC_BYTE = 1'b0,
      FUNC_TICK = 1'b1
   } func_type;

   typedef enum logic {
      EVENT_CHANNEL   = 1'b0,
      EVENT_LINK_LOST = 1'b1
   } event_type;

   typedef struct packed {
      event_type               kind;
      logic [PAYLOAD_BITS-1:0] payload;
   } job_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_CHAN,
      BACK_LOST
   } back_state_type;

   function automatic logic addr_ok(input logic [7:0] b);
      return (b == ADDR_FC) || (b == ADDR_RADIO) || (b == ADDR_RECEIVER) ||
             (b == ADDR_TX) || (b == ADDR_BROADCAST);
   endfunction

   function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

endpackage

// ===== rtl/crsfr_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crsfr_front
// Takes bytes and ticks, does framing, crc check and link timing, and
// queues one job per good frame or link loss.
// ----------------------------------------------------------------------------
module crsfr_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  logic              req_func,
   input  logic [7:0]        req_data_byte,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [15:0]       csr_data,
   input  logic              job_full,
   output logic              job_push,
   output crsfr_pkg::job_type job_data
);
   import crsfr_pkg::*;

   logic [6:0]  pos_ff, pos_in;
   logic [5:0]  len_ff, len_in;
   logic [7:0]  type_ff, type_in;
   logic [7:0]  crc_ff, crc_in;
   logic        link_ff, link_in;
   logic [15:0] ms_ff, ms_in;
   logic [15:0] timeout_ff;
   logic [7:0]  payload_ff [PAYLOAD_BYTES];

   logic        accept;
   logic [6:0]  frame_end;
   logic [6:0]  store_idx;
   logic        store_en;
   logic        frame_good;

   assign req_full  = job_full;
   assign csr_ready = 1'b1;
   assign accept    = req_push & ~req_full;
   assign frame_end = {1'b0, len_ff} + 7'd1;
   assign store_idx = pos_ff - 7'd3;
   assign frame_good = (req_data_byte == crc_ff) && (type_ff == RC_TYPE) &&
                       (len_ff == RC_LENGTH);

   always_comb begin
      pos_in   = pos_ff;
      len_in   = len_ff;
      type_in  = type_ff;
      crc_in   = crc_ff;
      link_in  = link_ff;
      ms_in    = ms_ff;
      store_en = 1'b0;
      job_push = 1'b0;
      job_data.kind = EVENT_CHANNEL;
      for (int i = 0; i < PAYLOAD_BYTES; i++) begin
         job_data.payload[i*8 +: 8] = payload_ff[i];
      end
      if (accept) begin
         if (func_type'(req_func) == FUNC_TICK) begin
            if (link_ff) begin
               if (ms_ff >= timeout_ff) begin
                  link_in       = 1'b0;
                  job_push      = 1'b1;
                  job_data.kind = EVENT_LINK_LOST;
               end else begin
                  ms_in = ms_ff + 16'd1;
               end
            end
         end else if (pos_ff == 7'd0) begin
            if (addr_ok(req_data_byte)) begin
               pos_in = 7'd1;
            end
         end else if (pos_ff == 7'd1) begin
            if ((req_data_byte < MIN_LENGTH) || (req_data_byte > MAX_LENGTH)) begin
               pos_in = 7'd0;
               len_in = 6'd0;
            end else begin
               len_in = req_data_byte[5:0];
               crc_in = 8'd0;
               pos_in = 7'd2;
            end
         end else if (pos_ff >= frame_end) begin
            pos_in = 7'd0;
            len_in = 6'd0;
            if (frame_good) begin
               link_in  = 1'b1;
               ms_in    = 16'd0;
               job_push = 1'b1;
            end
         end else begin
            if (pos_ff == 7'd2) begin
               type_in = req_data_byte;
            end else if (store_idx < 7'(PAYLOAD_BYTES)) begin
               store_en = 1'b1;
            end
            crc_in = crc_byte(crc_ff, req_data_byte);
            pos_in = pos_ff + 7'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         len_ff     <= '0;
         type_ff    <= '0;
         crc_ff     <= '0;
         link_ff    <= 1'b0;
         ms_ff      <= '0;
         timeout_ff <= TIMEOUT_RESET;
      end else begin
         pos_ff  <= pos_in;
         len_ff  <= len_in;
         type_ff <= type_in;
         crc_ff  <= crc_in;
         link_ff <= link_in;
         ms_ff   <= ms_in;
         if (csr_valid && csr_ready) begin
            timeout_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (store_en) begin
         payload_ff[store_idx[PAYLOAD_IDX_W-1:0]] <= req_data_byte;
      end
   end

   // a job is only raised for an accepted item
   assert property (@(posedge clock) disable iff (reset) job_push |-> accept)
      else $error("job raised without an accepted item");

   // a good frame always leaves the link up with a fresh timer
   assert property (@(posedge clock) disable iff (reset)
      (job_push && job_data.kind == EVENT_CHANNEL) |=> (link_ff && ms_ff == 16'd0 &&
      pos_ff == 7'd0))
      else $error("good frame did not restart link timing");

   // link loss always drops the link
   assert property (@(posedge clock) disable iff (reset)
      (job_push && job_data.kind == EVENT_LINK_LOST) |=> !link_ff)
      else $error("link loss did not drop the link");

endmodule

// ===== rtl/crsfr_job_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crsfr_job_queue
// Short fifo of jobs between the framing front and the result back end.
// ----------------------------------------------------------------------------
module crsfr_job_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  crsfr_pkg::job_type push_data,
   input  logic               pop,
   output logic               empty,
   output crsfr_pkg::job_type pop_data
);
   import crsfr_pkg::*;

   job_type             entry_ff [JOB_QUEUE_DEPTH];
   logic [JQ_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [JQ_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [JQ_CNT_W-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign full     = (count_ff == JQ_CNT_W'(JOB_QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == JQ_PTR_W'(JOB_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == JQ_PTR_W'(JOB_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/crsfr_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crsfr_back
// Turns queued jobs into result items: sixteen unpacked channels per good
// frame, or one link lost item.
// ----------------------------------------------------------------------------
module crsfr_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               job_empty,
   output logic               job_pop,
   input  crsfr_pkg::job_type job_data,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic               rsp_event_kind,
   output logic [3:0]         rsp_channel_index,
   output logic [10:0]        rsp_channel_value,
   output logic               rsp_last_of_run
);
   import crsfr_pkg::*;

   back_state_type          state_ff, state_in;
   logic [3:0]              idx_ff, idx_in;
   logic [PAYLOAD_BITS-1:0] shreg_ff, shreg_in;
   logic                    last_chan;
   logic                    taken;

   assign last_chan = (idx_ff == 4'(NUM_CHANNELS - 1));
   assign taken     = rsp_pop & ~rsp_empty;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BACK_IDLE: begin
            if (!job_empty) begin
               state_in = (job_data.kind == EVENT_LINK_LOST) ? BACK_LOST : BACK_CHAN;
            end
         end
         BACK_CHAN: begin
            if (taken && last_chan) begin
               state_in = BACK_IDLE;
            end
         end
         BACK_LOST: begin
            if (taken) begin
               state_in = BACK_IDLE;
            end
         end
         default: state_in = BACK_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      job_pop           = 1'b0;
      idx_in            = idx_ff;
      shreg_in          = shreg_ff;
      rsp_empty         = 1'b1;
      rsp_event_kind    = EVENT_CHANNEL;
      rsp_channel_index = 4'd0;
      rsp_channel_value = 11'd0;
      rsp_last_of_run   = 1'b0;
      unique case (state_ff)
         BACK_IDLE: begin
            job_pop  = ~job_empty;
            idx_in   = 4'd0;
            shreg_in = job_data.payload;
         end
         BACK_CHAN: begin
            rsp_empty         = 1'b0;
            rsp_channel_index = idx_ff;
            rsp_channel_value = shreg_ff[CH_BITS-1:0];
            rsp_last_of_run   = last_chan;
            if (taken) begin
               idx_in   = idx_ff + 4'd1;
               shreg_in = shreg_ff >> CH_BITS;
            end
         end
         BACK_LOST: begin
            rsp_empty       = 1'b0;
            rsp_event_kind  = EVENT_LINK_LOST;
            rsp_last_of_run = 1'b1;
         end
         default: begin
            rsp_empty = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BACK_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      shreg_ff <= shreg_in;
   end

   // a stalled channel item holds
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == BACK_CHAN && !rsp_pop) |=> (state_ff == BACK_CHAN && $stable(idx_ff)))
      else $error("stalled channel item changed");

   // run ends after the last channel is taken
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == BACK_CHAN && rsp_pop && last_chan) |=> state_ff == BACK_IDLE)
      else $error("channel run did not end");

   // a loaded run always starts at channel zero
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == BACK_IDLE && !job_empty) |=> idx_ff == 4'd0)
      else $error("run did not start at channel zero");

endmodule

// ===== rtl/crsf_rc_frame_receiver_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crsf_rc_frame_receiver_unit
// Rc channels frame receiver: framing and crc front, job queue, and a back
// end that unpacks eleven-bit channels or reports link loss.
// ----------------------------------------------------------------------------
// a frame's first result is on the ports once its job, pushed when the crc byte
// is taken, has passed the job queue register and the back end state register
// throughput: one input item per cycle while the two-entry job queue has room
// a good frame gives sixteen results at one per cycle while they are popped, set by the channel shifter
// the back end passes through its idle state between jobs while it loads the next one
// reset clears all control state, timeout returns to 500, no sweep
// ----------------------------------------------------------------------------
module crsf_rc_frame_receiver_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_func,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic        rsp_event_kind,
   output logic [3:0]  rsp_channel_index,
   output logic [10:0] rsp_channel_value,
   output logic        rsp_last_of_run,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);
   import crsfr_pkg::*;

   logic    fq_push, fq_full, fq_pop, fq_empty;
   job_type fq_push_data, fq_pop_data;

   crsfr_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_func      (req_func),
      .req_data_byte (req_data_byte),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_data      (csr_data),
      .job_full      (fq_full),
      .job_push      (fq_push),
      .job_data      (fq_push_data)
   );

   crsfr_job_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (fq_push),
      .full      (fq_full),
      .push_data (fq_push_data),
      .pop       (fq_pop),
      .empty     (fq_empty),
      .pop_data  (fq_pop_data)
   );

   crsfr_back u_back (
      .clock             (clock),
      .reset             (reset),
      .job_empty         (fq_empty),
      .job_pop           (fq_pop),
      .job_data          (fq_pop_data),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_event_kind    (rsp_event_kind),
      .rsp_channel_index (rsp_channel_index),
      .rsp_channel_value (rsp_channel_value),
      .rsp_last_of_run   (rsp_last_of_run)
   );

endmodule
